>>> design/command_line_whitespace_normalizer_unit_defines.svh
// Assertion macros shared by the checker of the whitespace normalizer.
`ifndef COMMAND_LINE_WHITESPACE_NORMALIZER_UNIT_DEFINES_SVH
`define COMMAND_LINE_WHITESPACE_NORMALIZER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CWN_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CWN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/cwn_pkg.sv
// Shared types, constants and helpers of the whitespace normalizer.
package cwn_pkg;

  localparam int unsigned PENDING_DEPTH_DEF = 32;
  localparam logic [7:0]  SPACE_CHAR        = 8'h20;
  localparam logic [7:0]  TAB_CHAR          = 8'h09;
  localparam logic [7:0]  CR_CHAR           = 8'h0D;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic flush_emit;  // move next held whitespace byte to the output
    logic hold_emit;   // move the held non-whitespace byte to the output
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic ld_ok;       // output register can take a beat
    logic go_flush;    // current input needs the pending store flushed first
    logic go_hold;     // current input emits a space and then itself
    logic flush_last;  // flush index points at the last held byte
  } dp_sts_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
  endfunction

endpackage

>>> design/cwn_ctrl.sv
// Controller state machine: accept, flush and held-byte sequencing.
module cwn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cwn_pkg::dp_sts_t sts_i,
  output cwn_pkg::ctl_cmd_t cmd_o
);
  import cwn_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_HOLD} state_e;

  state_e state_q, state_d;

  always_comb begin
    in_ready_o       = (state_q == S_IDLE) && sts_i.ld_ok;
    cmd_o.accept     = in_valid_i && in_ready_o;
    cmd_o.flush_emit = (state_q == S_FLUSH) && sts_i.ld_ok;
    cmd_o.hold_emit  = (state_q == S_HOLD) && sts_i.ld_ok;
    state_d          = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && sts_i.go_flush) begin
          state_d = S_FLUSH;
        end else if (cmd_o.accept && sts_i.go_hold) begin
          state_d = S_HOLD;
        end
      end
      S_FLUSH: begin
        if (cmd_o.flush_emit && sts_i.flush_last) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (cmd_o.hold_emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/cwn_datapath.sv
// Datapath: line state, pending whitespace store and output register.
module cwn_datapath #(
  parameter int unsigned PENDING_DEPTH = cwn_pkg::PENDING_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic              in_marker_i,
  input  logic              line_end_i,
  input  cwn_pkg::ctl_cmd_t cmd_i,
  output cwn_pkg::dp_sts_t  sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              end_of_line_o,
  output logic              line_changed_o,
  output logic              overflow_o
);
  import cwn_pkg::*;

  localparam int unsigned AW = $clog2(PENDING_DEPTH);
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

  typedef enum logic [1:0] {PH_LEAD, PH_CMD, PH_GAP, PH_ARG} phase_e;

  phase_e        phase_q, phase_d;
  logic [1:0]    gap_len_q, gap_len_d;
  logic          gap_sp_q, gap_sp_d;
  logic          changed_q, changed_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] pcnt_q, pcnt_d;
  logic [AW-1:0] idx_q, idx_d, rd_addr;

  logic [7:0]    mem_q [PENDING_DEPTH];
  logic [7:0]    rd_data_q;
  logic [7:0]    hold_q;

  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_eol_q, out_chg_q, out_ovf_q;

  logic          is_term, ws, wr_en, chg_v;
  logic          acc_emit, acc_eol, acc_chg, out_ld;
  logic [7:0]    acc_byte;

  assign is_term = in_marker_i || line_end_i;
  assign ws      = is_ws(data_byte_i);

  assign sts_o.ld_ok      = !out_valid_q || out_ready_i;
  assign sts_o.go_flush   = !is_term && (phase_q == PH_ARG) && !ws && (pcnt_q != '0);
  assign sts_o.go_hold    = !is_term && (phase_q == PH_GAP) && !ws;
  assign sts_o.flush_last = (CW'(idx_q) + CW'(1)) == pcnt_q;

  always_comb begin
    phase_d   = phase_q;
    gap_len_d = gap_len_q;
    gap_sp_d  = gap_sp_q;
    changed_d = changed_q;
    ovf_d     = ovf_q;
    pcnt_d    = pcnt_q;
    idx_d     = idx_q;
    chg_v     = changed_q;
    wr_en     = 1'b0;
    acc_emit  = 1'b0;
    acc_byte  = data_byte_i;
    acc_eol   = 1'b0;
    acc_chg   = 1'b0;
    if (cmd_i.accept) begin
      idx_d = '0;
      if (is_term) begin
        // Drop held trailing whitespace or an unfinished gap.
        if ((phase_q == PH_ARG) && (pcnt_q != '0)) begin
          chg_v  = 1'b1;
          pcnt_d = '0;
        end
        if ((phase_q == PH_GAP) && (gap_len_q != 2'd0)) begin
          chg_v     = 1'b1;
          gap_len_d = 2'd0;
        end
        changed_d = chg_v;
        acc_emit  = 1'b1;
        acc_eol   = line_end_i;
        acc_chg   = line_end_i && chg_v;
        if (line_end_i) begin
          phase_d   = PH_LEAD;
          gap_len_d = 2'd0;
          gap_sp_d  = 1'b0;
          changed_d = 1'b0;
          ovf_d     = 1'b0;
          pcnt_d    = '0;
        end
      end else begin
        case (phase_q)
          PH_LEAD: begin
            if (ws) begin
              changed_d = 1'b1;
            end else begin
              phase_d  = PH_CMD;
              acc_emit = 1'b1;
            end
          end
          PH_CMD: begin
            if (ws) begin
              phase_d   = PH_GAP;
              gap_len_d = 2'd1;
              gap_sp_d  = (data_byte_i == SPACE_CHAR);
            end else begin
              acc_emit = 1'b1;
            end
          end
          PH_GAP: begin
            if (ws) begin
              if (gap_len_q == 2'd0) begin
                gap_sp_d = (data_byte_i == SPACE_CHAR);
              end
              if (gap_len_q != 2'd2) begin
                gap_len_d = gap_len_q + 2'd1;
              end
            end else begin
              if ((gap_len_q != 2'd1) || !gap_sp_q) begin
                changed_d = 1'b1;
              end
              gap_len_d = 2'd0;
              phase_d   = PH_ARG;
              pcnt_d    = '0;
              acc_emit  = 1'b1;
              acc_byte  = SPACE_CHAR;
            end
          end
          default: begin
            if (ws) begin
              if (pcnt_q < CW'(PENDING_DEPTH)) begin
                wr_en  = 1'b1;
                pcnt_d = pcnt_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end else if (pcnt_q == '0) begin
              acc_emit = 1'b1;
            end
          end
        endcase
      end
    end else if (cmd_i.flush_emit) begin
      idx_d = idx_q + AW'(1);
      if (sts_o.flush_last) begin
        pcnt_d = '0;
      end
    end
  end

  // Keep the next byte to flush in the read register.
  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = '0;
    end else if (cmd_i.flush_emit) begin
      rd_addr = idx_q + AW'(1);
    end else begin
      rd_addr = idx_q;
    end
  end

  assign out_ld = acc_emit || cmd_i.flush_emit || cmd_i.hold_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      gap_len_q   <= 2'd0;
      gap_sp_q    <= 1'b0;
      changed_q   <= 1'b0;
      ovf_q       <= 1'b0;
      pcnt_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      gap_len_q <= gap_len_d;
      gap_sp_q  <= gap_sp_d;
      changed_q <= changed_d;
      ovf_q     <= ovf_d;
      pcnt_q    <= pcnt_d;
      idx_q     <= idx_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pcnt_q[AW-1:0]] <= data_byte_i;
    end
    rd_data_q <= mem_q[rd_addr];
    if (cmd_i.accept) begin
      hold_q <= data_byte_i;
    end
    if (out_ld) begin
      out_ovf_q <= ovf_q;
      if (cmd_i.flush_emit) begin
        out_byte_q <= rd_data_q;
        out_eol_q  <= 1'b0;
        out_chg_q  <= 1'b0;
      end else if (cmd_i.hold_emit) begin
        out_byte_q <= hold_q;
        out_eol_q  <= 1'b0;
        out_chg_q  <= 1'b0;
      end else begin
        out_byte_q <= acc_byte;
        out_eol_q  <= acc_eol;
        out_chg_q  <= acc_chg;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign end_of_line_o  = out_eol_q;
  assign line_changed_o = out_chg_q;
  assign overflow_o     = out_ovf_q;

endmodule

>>> design/command_line_whitespace_normalizer_unit.sv
// Top level of the command line whitespace normalizer.
// A beat that yields a byte shows it on the output in the cycle after acceptance.
// Throughput: one input beat per cycle while the output is not stalled and no held bytes
// drain: held whitespace flushes before the next argument byte, a space before the first.
// The flush rate is set by the single read port of the pending whitespace store.
// Reset (rst_ni low, asynchronous) returns the line state and output valid to idle.
module command_line_whitespace_normalizer_unit #(
  parameter int unsigned PENDING_DEPTH = cwn_pkg::PENDING_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input beat: one byte of the command line
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       in_marker_i,
  input  logic       line_end_i,
  // Output beat: one byte of the canonical line
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_line_o,
  output logic       line_changed_o,
  output logic       overflow_o
);
  import cwn_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The controller decides when to take a beat and when to drain held bytes;
  // it never touches payload.
  cwn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath tracks the line phase, holds argument whitespace in its store,
  // and owns the output register that parts the two handshakes.
  cwn_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .in_marker_i    (in_marker_i),
    .line_end_i     (line_end_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .end_of_line_o  (end_of_line_o),
    .line_changed_o (line_changed_o),
    .overflow_o     (overflow_o)
  );

endmodule

>>> design/cwn_checker.sv
// Port-level checker of the whitespace normalizer and its bind.
`include "command_line_whitespace_normalizer_unit_defines.svh"

module cwn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       in_marker_i,
  input logic       line_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       end_of_line_o,
  input logic       line_changed_o,
  input logic       overflow_o
);

  `CWN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o), "output beat dropped or changed while stalled")
  `CWN_ASSERT_SAME(a_chg_at_eol, clk_i, rst_ni, out_valid_o && line_changed_o, end_of_line_o, "line_changed set away from end of line")
  `CWN_ASSERT_SAME(a_no_take_stalled, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "input taken while output register is stalled")

endmodule

bind command_line_whitespace_normalizer_unit cwn_checker u_cwn_checker (.*);
